### hw/rtl/c_subset_lexer_with_symbol_table_core_defines.svh
// Assertion macros shared by the lexer RTL.
`ifndef C_SUBSET_LEXER_WITH_SYMBOL_TABLE_CORE_DEFINES_SVH
`define C_SUBSET_LEXER_WITH_SYMBOL_TABLE_CORE_DEFINES_SVH

// Same-cycle implication.
`define CSL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csl assertion failed");

// Next-cycle implication.
`define CSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csl assertion failed");

`endif

### hw/rtl/csl_pkg.sv
`default_nettype none
package csl_pkg;

   localparam int MAX_NAME_DEF    = 16;
   localparam int MAX_SYMBOLS_DEF = 64;
   localparam int KW_COUNT        = 34;
   localparam int KW_PRINTF       = 32;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_PCT   = 8'h25;

   localparam logic [2:0] CLS_ARITH = 3'd0;
   localparam logic [2:0] CLS_KW    = 3'd1;
   localparam logic [2:0] CLS_NEW   = 3'd2;
   localparam logic [2:0] CLS_KNOWN = 3'd3;
   localparam logic [2:0] CLS_REL   = 3'd4;
   localparam logic [2:0] CLS_ASGN  = 3'd5;

   localparam logic [2:0] REL_LT = 3'd0;
   localparam logic [2:0] REL_GT = 3'd1;
   localparam logic [2:0] REL_LE = 3'd2;
   localparam logic [2:0] REL_GE = 3'd3;
   localparam logic [2:0] REL_EQ = 3'd4;

   typedef enum logic [2:0] {
      EM_REL   = 3'd0,
      EM_FLUSH = 3'd1,
      EM_ARITH = 3'd2,
      EM_KW    = 3'd3,
      EM_KNOWN = 3'd4,
      EM_NEW   = 3'd5
   } emit_sel_type;

   typedef struct packed {
      logic         accept;
      logic         emit;
      emit_sel_type sel;
      logic         clr_pending;
      logic         set_pending;
      logic         next_line;
      logic         clr_skip;
      logic         set_skip;
      logic         append;
      logic         clr_run;
      logic         srch_start;
      logic         idx_next;
      logic         k_clear;
      logic         k_inc;
      logic         release_last;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic pending;
      logic c_eq;
      logic c_nl;
      logic c_alpha;
      logic c_alnum;
      logic c_arith;
      logic c_relop;
      logic end_flag;
      logic run_active;
      logic kw_hit;
      logic kw_printf;
      logic idx_at_count;
      logic len_match;
      logic chr_match;
      logic chr_last;
      logic can_push;
      logic out_free;
      logic held_valid;
   } status_type;

   typedef struct packed {
      logic [2:0]  token_class;
      logic [7:0]  op_char;
      logic [2:0]  rel_kind;
      logic [5:0]  keyword_number;
      logic [6:0]  symbol_number;
      logic [15:0] line_number;
      logic        name_truncated;
      logic        table_full;
   } rsp_type;

   // Keyword text, left aligned, padded with spaces (a space never occurs in a run).
   function automatic logic [63:0] kw_text(input int unsigned i);
      logic [63:0] t;
      case (i)
         0:  t = "auto    ";
         1:  t = "break   ";
         2:  t = "case    ";
         3:  t = "char    ";
         4:  t = "const   ";
         5:  t = "continue";
         6:  t = "default ";
         7:  t = "do      ";
         8:  t = "double  ";
         9:  t = "else    ";
         10: t = "enum    ";
         11: t = "extern  ";
         12: t = "float   ";
         13: t = "for     ";
         14: t = "goto    ";
         15: t = "if      ";
         16: t = "int     ";
         17: t = "long    ";
         18: t = "register";
         19: t = "return  ";
         20: t = "short   ";
         21: t = "signed  ";
         22: t = "sizeof  ";
         23: t = "static  ";
         24: t = "struct  ";
         25: t = "switch  ";
         26: t = "typedef ";
         27: t = "union   ";
         28: t = "unsigned";
         29: t = "void    ";
         30: t = "volatile";
         31: t = "while   ";
         32: t = "printf  ";
         33: t = "scanf   ";
         default: t = "        ";
      endcase
      return t;
   endfunction

   function automatic logic [3:0] kw_len(input int unsigned i);
      logic [63:0] t;
      logic [3:0]  n;
      t = kw_text(i);
      n = 4'd0;
      for (int p = 0; p < 8; p++) begin
         if (t[8*(7-p) +: 8] != 8'h20) begin
            n = n + 4'd1;
         end
      end
      return n;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/csl_ram.sv
`default_nettype none
module csl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

### hw/rtl/csl_ctrl.sv
`default_nettype none
`include "c_subset_lexer_with_symbol_table_core_defines.svh"
module csl_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire csl_pkg::status_type status,
   output csl_pkg::cmd_type         cmd
);

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_PEND  = 13'b0000000000010,
      S_RUN   = 13'b0000000000100,
      S_REST  = 13'b0000000001000,
      S_END   = 13'b0000000010000,
      S_KW    = 13'b0000000100000,
      S_SLEN  = 13'b0000001000000,
      S_SLENW = 13'b0000010000000,
      S_CHR   = 13'b0000100000000,
      S_CHK   = 13'b0001000000000,
      S_FOUND = 13'b0010000000000,
      S_NEW   = 13'b0100000000000,
      S_DONE  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      ctx_end_ff, ctx_end_in;   // run finish was started by end of text

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ctx_end_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ctx_end_ff <= ctx_end_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ctx_end_in = ctx_end_ff;
      cmd        = '0;
      cmd.sel    = csl_pkg::EM_ARITH;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_PEND;
            end
         end
         S_PEND: begin
            if (status.skip) begin
               cmd.clr_skip  = status.c_nl;
               cmd.next_line = status.c_nl;
               state_in      = S_END;
            end else if (status.pending) begin
               if (status.can_push) begin
                  cmd.emit        = 1'b1;
                  cmd.sel         = status.c_eq ? csl_pkg::EM_REL : csl_pkg::EM_FLUSH;
                  cmd.clr_pending = 1'b1;
                  state_in        = status.c_eq ? S_END : S_RUN;
               end
            end else begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (status.run_active) begin
               if (status.c_alnum) begin
                  cmd.append = 1'b1;
                  state_in   = S_END;
               end else begin
                  ctx_end_in = 1'b0;
                  state_in   = S_KW;
               end
            end else begin
               state_in = S_REST;
            end
         end
         S_REST: begin
            if (status.c_arith) begin
               if (status.can_push) begin
                  cmd.emit = 1'b1;
                  cmd.sel  = csl_pkg::EM_ARITH;
                  state_in = S_END;
               end
            end else begin
               cmd.append      = status.c_alpha;
               cmd.set_pending = status.c_relop;
               cmd.next_line   = status.c_nl;
               state_in        = S_END;
            end
         end
         S_END: begin
            if (!status.end_flag) begin
               state_in = S_DONE;
            end else if (status.pending) begin
               if (status.can_push) begin
                  cmd.emit        = 1'b1;
                  cmd.sel         = csl_pkg::EM_FLUSH;
                  cmd.clr_pending = 1'b1;
               end
            end else if (status.run_active) begin
               ctx_end_in = 1'b1;
               state_in   = S_KW;
            end else begin
               cmd.clr_skip = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_KW: begin
            if (status.kw_hit) begin
               if (status.can_push) begin
                  cmd.emit    = 1'b1;
                  cmd.sel     = csl_pkg::EM_KW;
                  cmd.clr_run = 1'b1;
                  if (!ctx_end_ff && status.kw_printf) begin
                     // printf: rest of the line is ignored, starting with this byte; a newline here ends the skip
                     cmd.set_skip  = 1'b1;
                     cmd.next_line = status.c_nl;
                     state_in      = S_END;
                  end else begin
                     state_in = ctx_end_ff ? S_END : S_REST;
                  end
               end
            end else begin
               cmd.srch_start = 1'b1;
               state_in       = S_SLEN;
            end
         end
         S_SLEN: begin
            state_in = status.idx_at_count ? S_NEW : S_SLENW;
         end
         S_SLENW: begin
            if (status.len_match) begin
               cmd.k_clear = 1'b1;
               state_in    = S_CHR;
            end else begin
               cmd.idx_next = 1'b1;
               state_in     = S_SLEN;
            end
         end
         S_CHR: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            if (!status.chr_match) begin
               cmd.idx_next = 1'b1;
               state_in     = S_SLEN;
            end else if (status.chr_last) begin
               state_in = S_FOUND;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = S_CHR;
            end
         end
         S_FOUND, S_NEW: begin
            if (status.can_push) begin
               cmd.emit    = 1'b1;
               cmd.sel     = (state_ff == S_FOUND) ? csl_pkg::EM_KNOWN : csl_pkg::EM_NEW;
               cmd.clr_run = 1'b1;
               state_in    = ctx_end_ff ? S_END : S_REST;
            end
         end
         S_DONE: begin
            if (!status.held_valid) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.release_last = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `CSL_ASSERT_IMPL(a_ready_no_held, clock, reset, req_ready, !status.held_valid)
   `CSL_ASSERT_IMPL(a_emit_room, clock, reset, cmd.emit, status.can_push)
   `CSL_ASSERT_IMPL(a_release_room, clock, reset, cmd.release_last,
                    status.held_valid && status.out_free)
   `CSL_ASSERT_NEXT(a_append_leaves, clock, reset, cmd.append, state_ff == S_END)

endmodule
`default_nettype wire

### hw/rtl/csl_dpath.sv
`default_nettype none
module csl_dpath #(
   parameter int MAX_NAME    = csl_pkg::MAX_NAME_DEF,
   parameter int MAX_SYMBOLS = csl_pkg::MAX_SYMBOLS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire csl_pkg::cmd_type cmd,
   output csl_pkg::status_type   status,
   input  wire logic [7:0]       req_char_in,
   input  wire logic             req_end_of_text,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output csl_pkg::rsp_type      rsp_data,
   output logic                  rsp_run_last
);

   localparam int NL_W   = $clog2(MAX_NAME + 1);
   localparam int NI_W   = $clog2(MAX_NAME);
   localparam int SC_W   = $clog2(MAX_SYMBOLS + 1);
   localparam int IDX_W  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int CDEPTH = MAX_SYMBOLS * MAX_NAME;
   localparam int CA_W   = $clog2(CDEPTH);
   localparam int BASE_W = $clog2(CDEPTH + 1);
   localparam int KWN    = csl_pkg::KW_COUNT;

   localparam logic [1:0] PK_NONE = 2'd0;
   localparam logic [1:0] PK_LT   = 2'd1;
   localparam logic [1:0] PK_GT   = 2'd2;
   localparam logic [1:0] PK_EQ   = 2'd3;

   logic [7:0]        c_ff;
   logic              end_ff;
   logic [NL_W-1:0]   len_ff, len_in;
   logic              cut_ff, cut_in;
   logic [1:0]        pend_ff, pend_in;
   logic              skip_ff, skip_in;
   logic [15:0]       line_ff, line_in;
   logic [SC_W-1:0]   count_ff, count_in;
   logic [BASE_W-1:0] nbase_ff, nbase_in;   // char slot of the next new symbol
   logic [SC_W-1:0]   idx_ff;
   logic [BASE_W-1:0] base_ff;
   logic [NI_W-1:0]   k_ff;
   logic [KWN-1:0]    mask_ff;
   logic [KWN-1:0]    kw_step, kw_match;
   logic [5:0]        kw_num;
   logic              held_valid_ff, held_valid_in;
   csl_pkg::rsp_type  held_ff, held_in;
   logic              rsp_valid_ff, rsp_valid_in;
   csl_pkg::rsp_type  rsp_ff, rsp_in;
   logic              last_ff, last_in;
   csl_pkg::rsp_type  new_rsp;

   logic              has_room, table_space, push, out_free;
   logic [7:0]        name_rd, sym_rd;
   logic [NL_W-1:0]   slen_rd;
   logic [BASE_W-1:0] caddr_rd, caddr_wr;
   logic [31:0]       sym_known, sym_new;

   assign has_room    = len_ff < NL_W'(MAX_NAME);
   assign table_space = count_ff < SC_W'(MAX_SYMBOLS);
   assign caddr_wr    = nbase_ff + BASE_W'(len_ff);
   assign caddr_rd    = base_ff + BASE_W'(k_ff);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign push        = cmd.emit;

   csl_ram #(.WIDTH(8), .DEPTH(MAX_NAME)) u_name (
      .clock   (clock),
      .wr_en   (cmd.append && has_room),
      .wr_addr (len_ff[NI_W-1:0]),
      .wr_data (c_ff),
      .rd_addr (k_ff),
      .rd_data (name_rd)
   );

   // chars are written speculatively into the next free slot while the run grows
   csl_ram #(.WIDTH(8), .DEPTH(CDEPTH)) u_chars (
      .clock   (clock),
      .wr_en   (cmd.append && has_room && table_space),
      .wr_addr (caddr_wr[CA_W-1:0]),
      .wr_data (c_ff),
      .rd_addr (caddr_rd[CA_W-1:0]),
      .rd_data (sym_rd)
   );

   csl_ram #(.WIDTH(NL_W), .DEPTH(MAX_SYMBOLS)) u_lens (
      .clock   (clock),
      .wr_en   (push && cmd.sel == csl_pkg::EM_NEW && table_space),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (len_ff),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (slen_rd)
   );

   // keyword candidates narrowed one character at a time
   always_comb begin
      logic [63:0] t;
      logic [7:0]  b;
      kw_num = '0;
      for (int i = 0; i < KWN; i++) begin
         t           = csl_pkg::kw_text(i);
         b           = t[8*(7 - int'(len_ff[2:0])) +: 8];
         kw_step[i]  = (len_ff < NL_W'(8)) && (b == c_ff);
         kw_match[i] = mask_ff[i] && !cut_ff && (NL_W'(csl_pkg::kw_len(i)) == len_ff);
      end
      for (int i = KWN - 1; i >= 0; i--) begin
         if (kw_match[i]) begin
            kw_num = 6'(i);
         end
      end
   end

   assign sym_known = 32'(idx_ff) + 32'd1;
   assign sym_new   = 32'(count_ff) + 32'd1;

   always_comb begin
      new_rsp             = '0;
      new_rsp.line_number = line_ff;
      case (cmd.sel)
         csl_pkg::EM_REL: begin
            new_rsp.token_class = csl_pkg::CLS_REL;
            case (pend_ff)
               PK_LT: begin
                  new_rsp.op_char  = csl_pkg::CH_LT;
                  new_rsp.rel_kind = csl_pkg::REL_LE;
               end
               PK_GT: begin
                  new_rsp.op_char  = csl_pkg::CH_GT;
                  new_rsp.rel_kind = csl_pkg::REL_GE;
               end
               default: begin
                  new_rsp.op_char  = csl_pkg::CH_EQ;
                  new_rsp.rel_kind = csl_pkg::REL_EQ;
               end
            endcase
         end
         csl_pkg::EM_FLUSH: begin
            case (pend_ff)
               PK_LT: begin
                  new_rsp.token_class = csl_pkg::CLS_REL;
                  new_rsp.op_char     = csl_pkg::CH_LT;
                  new_rsp.rel_kind    = csl_pkg::REL_LT;
               end
               PK_GT: begin
                  new_rsp.token_class = csl_pkg::CLS_REL;
                  new_rsp.op_char     = csl_pkg::CH_GT;
                  new_rsp.rel_kind    = csl_pkg::REL_GT;
               end
               default: begin
                  new_rsp.token_class = csl_pkg::CLS_ASGN;
                  new_rsp.op_char     = csl_pkg::CH_EQ;
               end
            endcase
         end
         csl_pkg::EM_ARITH: begin
            new_rsp.token_class = csl_pkg::CLS_ARITH;
            new_rsp.op_char     = c_ff;
         end
         csl_pkg::EM_KW: begin
            new_rsp.token_class    = csl_pkg::CLS_KW;
            new_rsp.keyword_number = kw_num;
         end
         csl_pkg::EM_KNOWN: begin
            new_rsp.token_class    = csl_pkg::CLS_KNOWN;
            new_rsp.symbol_number  = sym_known[6:0];
            new_rsp.name_truncated = cut_ff;
         end
         default: begin
            new_rsp.token_class    = csl_pkg::CLS_NEW;
            new_rsp.name_truncated = cut_ff;
            new_rsp.symbol_number  = table_space ? sym_new[6:0] : 7'd0;
            new_rsp.table_full     = !table_space;
         end
      endcase
   end

   always_comb begin
      len_in        = len_ff;
      cut_in        = cut_ff;
      pend_in       = pend_ff;
      skip_in       = skip_ff;
      line_in       = line_ff;
      count_in      = count_ff;
      nbase_in      = nbase_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      rsp_in        = rsp_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (cmd.append) begin
         if (has_room) begin
            len_in = len_ff + NL_W'(1);
         end else begin
            cut_in = 1'b1;
         end
      end
      if (cmd.clr_run) begin
         len_in = '0;
         cut_in = 1'b0;
      end
      if (cmd.clr_pending) begin
         pend_in = PK_NONE;
      end
      if (cmd.set_pending) begin
         if (c_ff == csl_pkg::CH_LT) begin
            pend_in = PK_LT;
         end else if (c_ff == csl_pkg::CH_GT) begin
            pend_in = PK_GT;
         end else begin
            pend_in = PK_EQ;
         end
      end
      if (cmd.set_skip) begin
         skip_in = (c_ff != csl_pkg::CH_NL);
      end
      if (cmd.clr_skip) begin
         skip_in = 1'b0;
      end
      if (cmd.next_line && line_ff != 16'hFFFF) begin
         line_in = line_ff + 16'd1;
      end
      if (push && cmd.sel == csl_pkg::EM_NEW && table_space) begin
         count_in = count_ff + SC_W'(1);
         nbase_in = nbase_ff + BASE_W'(MAX_NAME);
      end
      if (push) begin
         if (held_valid_ff) begin
            rsp_in       = held_ff;
            last_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end
         held_in       = new_rsp;
         held_valid_in = 1'b1;
      end
      if (cmd.release_last) begin
         rsp_in        = held_ff;
         last_in       = 1'b1;
         rsp_valid_in  = 1'b1;
         held_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         cut_ff        <= 1'b0;
         pend_ff       <= PK_NONE;
         skip_ff       <= 1'b0;
         line_ff       <= 16'd1;
         count_ff      <= '0;
         nbase_ff      <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         len_ff        <= len_in;
         cut_ff        <= cut_in;
         pend_ff       <= pend_in;
         skip_ff       <= skip_in;
         line_ff       <= line_in;
         count_ff      <= count_in;
         nbase_ff      <= nbase_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      rsp_ff  <= rsp_in;
      last_ff <= last_in;
      if (cmd.accept) begin
         c_ff   <= req_char_in;
         end_ff <= req_end_of_text;
      end
      if (cmd.append && has_room) begin
         mask_ff <= (len_ff == '0) ? kw_step : (mask_ff & kw_step);
      end
      if (cmd.srch_start) begin
         idx_ff  <= '0;
         base_ff <= '0;
      end else if (cmd.idx_next) begin
         idx_ff  <= idx_ff + SC_W'(1);
         base_ff <= base_ff + BASE_W'(MAX_NAME);
      end
      if (cmd.k_clear) begin
         k_ff <= '0;
      end else if (cmd.k_inc) begin
         k_ff <= k_ff + NI_W'(1);
      end
   end

   assign status.skip         = skip_ff;
   assign status.pending      = pend_ff != PK_NONE;
   assign status.c_eq         = c_ff == csl_pkg::CH_EQ;
   assign status.c_nl         = c_ff == csl_pkg::CH_NL;
   assign status.c_alpha      = c_ff inside {[8'h61:8'h7A], [8'h41:8'h5A]};
   assign status.c_alnum      = c_ff inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]};
   assign status.c_arith      = c_ff inside {csl_pkg::CH_PLUS, csl_pkg::CH_MINUS,
                                             csl_pkg::CH_STAR, csl_pkg::CH_SLASH,
                                             csl_pkg::CH_PCT};
   assign status.c_relop      = c_ff inside {csl_pkg::CH_LT, csl_pkg::CH_GT, csl_pkg::CH_EQ};
   assign status.end_flag     = end_ff;
   assign status.run_active   = len_ff != '0;
   assign status.kw_hit       = |kw_match;
   assign status.kw_printf    = kw_match[csl_pkg::KW_PRINTF];
   assign status.idx_at_count = idx_ff == count_ff;
   assign status.len_match    = slen_rd == len_ff;
   assign status.chr_match    = sym_rd == name_rd;
   assign status.chr_last     = (NL_W'(k_ff) + NL_W'(1)) == len_ff;
   assign status.can_push     = !held_valid_ff || out_free;
   assign status.out_free     = out_free;
   assign status.held_valid   = held_valid_ff;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;
   assign rsp_run_last = last_ff;

endmodule
`default_nettype wire

### hw/rtl/c_subset_lexer_with_symbol_table_core.sv
// Channel   Direction  Handshake             Beat
// req_      in         req_valid/req_ready   one source byte, end-of-text flag
// rsp_      out        rsp_valid/rsp_ready   one token, run_last on the byte's final token
//
// One byte at a time: req_ready is high only while idle, after the last byte is fully done.
// A byte that ends a run adds a keyword check and, for an identifier, a search that reads
// each stored length, then the chars on a match, through the single char memory read port.
// Reset is synchronous, no clearing pass; the symbol memories are never read unwritten.
// A stalled rsp_ side holds at most two tokens (output register plus one staged).
`default_nettype none
module c_subset_lexer_with_symbol_table_core #(
   parameter int MAX_NAME    = csl_pkg::MAX_NAME_DEF,
   parameter int MAX_SYMBOLS = csl_pkg::MAX_SYMBOLS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_in,
   input  wire logic        req_end_of_text,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_token_class,
   output logic [7:0]       rsp_op_char,
   output logic [2:0]       rsp_rel_kind,
   output logic [5:0]       rsp_keyword_number,
   output logic [6:0]       rsp_symbol_number,
   output logic [15:0]      rsp_line_number,
   output logic             rsp_name_truncated,
   output logic             rsp_table_full,
   output logic             rsp_run_last
);

   csl_pkg::cmd_type    cmd;
   csl_pkg::status_type status;
   csl_pkg::rsp_type    rsp_data;

   csl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   csl_dpath #(.MAX_NAME(MAX_NAME), .MAX_SYMBOLS(MAX_SYMBOLS)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_char_in     (req_char_in),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .rsp_run_last    (rsp_run_last)
   );

   assign rsp_token_class    = rsp_data.token_class;
   assign rsp_op_char        = rsp_data.op_char;
   assign rsp_rel_kind       = rsp_data.rel_kind;
   assign rsp_keyword_number = rsp_data.keyword_number;
   assign rsp_symbol_number  = rsp_data.symbol_number;
   assign rsp_line_number    = rsp_data.line_number;
   assign rsp_name_truncated = rsp_data.name_truncated;
   assign rsp_table_full     = rsp_data.table_full;

endmodule
`default_nettype wire
